[sv/hdau_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and saturation helper for the hyper-dual arithmetic unit.
package hdau_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	// four full 32x32 products summed without loss
	localparam int PROD_W    = 66;
	// an offset minus the rounded sum of products, or the rounded sum alone
	localparam int DOT_W     = PROD_W - FRAC_BITS + 1;

	localparam int DIV_LAT   = 35;
	localparam int DOT_LAT   = 3;

	// side line taps: where each quotient joins the item
	localparam int T_Q0      = DIV_LAT + 1;
	localparam int T_Q12P    = T_Q0 + DOT_LAT + DIV_LAT + 1;
	localparam int T_QM      = T_Q12P + DOT_LAT + DIV_LAT + 1;
	localparam int T_END     = T_QM + DOT_LAT;
	localparam int SIDE_N    = T_END + 1;

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [DATA_W-1:0] MAX_VAL  = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] MIN_VAL  = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD         = 4'd0,
		OP_SUB         = 4'd1,
		OP_MUL         = 4'd2,
		OP_DIV         = 4'd3,
		OP_NEG         = 4'd4,
		OP_ABS         = 4'd5,
		OP_RELU        = 4'd6,
		OP_SCALE       = 4'd7,
		OP_FROM_SCALAR = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	// one item as it travels down the side line
	typedef struct packed {
		logic [3:0]               op;
		logic signed [DATA_W-1:0] a_real;
		logic signed [DATA_W-1:0] a_eps1;
		logic signed [DATA_W-1:0] a_eps2;
		logic signed [DATA_W-1:0] a_eps12;
		logic signed [DATA_W-1:0] b_real;
		logic signed [DATA_W-1:0] b_eps1;
		logic signed [DATA_W-1:0] b_eps2;
		logic signed [DATA_W-1:0] b_eps12;
		logic signed [DATA_W-1:0] scalar;
		logic signed [DATA_W-1:0] q_real;
		logic signed [DATA_W-1:0] q_eps1;
		logic signed [DATA_W-1:0] q_eps2;
		logic signed [DATA_W-1:0] q_eps12;
		logic                     dflag;
	} pipe_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     sat;
	} sat_t;

	// clamp a wide signed value to the 32-bit range
	function automatic sat_t sat_wide(input logic signed [DOT_W-1:0] v);
		sat_t r;
		if (v[DOT_W-1:DATA_W-1] == '0 || v[DOT_W-1:DATA_W-1] == '1) begin
			r.val = v[DATA_W-1:0];
			r.sat = 1'b0;
		end else begin
			r.val = v[DOT_W-1] ? MIN_VAL : MAX_VAL;
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

[sv/hdau_dot4.sv]
`timescale 1ns / 1ps
// Three-stage rounded sum of four fixed-point products, optionally subtracted from an offset.
module hdau_dot4 import hdau_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DATA_W-1:0] x [4],
	input  logic signed [DATA_W-1:0] y [4],
	input  logic signed [DATA_W-1:0] c,
	input  logic                     sub,
	output logic signed [DOT_W-1:0]  res
);

	logic signed [2*DATA_W-1:0] prod_s1 [4];
	logic signed [DATA_W-1:0]   c_s1, c_s2;
	logic                       sub_s1, sub_s2;
	logic signed [PROD_W-1:0]   acc_s2;
	logic signed [DOT_W-1:0]    res_s3;
	logic signed [DOT_W-1:0]    rnd;

	// round once: floor of the sum plus one half
	assign rnd = DOT_W'(signed'(acc_s2[PROD_W-1:FRAC_BITS]));

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= x[i] * y[i];
			end
			c_s1   <= c;
			sub_s1 <= sub;
			acc_s2 <= PROD_W'(prod_s1[0]) + PROD_W'(prod_s1[1]) +
				PROD_W'(prod_s1[2]) + PROD_W'(prod_s1[3]) + RND_HALF;
			c_s2   <= c_s1;
			sub_s2 <= sub_s1;
			res_s3 <= sub_s2 ? DOT_W'(c_s2) - rnd : rnd;
		end
	end

	assign res = res_s3;

endmodule

[sv/hdau_div.sv]
`timescale 1ns / 1ps
// Pipelined fixed-point divider, one quotient bit per stage, truncating and saturating.
module hdau_div import hdau_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DOT_W-1:0]  num,
	input  logic signed [DATA_W-1:0] den,
	output logic signed [DATA_W-1:0] quo,
	output logic                     ovf
);

	localparam int SH  = DATA_W - FRAC_BITS;
	localparam int R0W = DOT_W - SH;

	logic [DOT_W-1:0]  un_s1;
	logic [DATA_W-1:0] ud_s1;
	logic              neg_s1;

	logic [DATA_W-1:0] rem_s [DATA_W+1];
	logic [DATA_W-1:0] low_s [DATA_W+1];
	logic [DATA_W-1:0] q_s   [DATA_W+1];
	logic [DATA_W-1:0] ud_s  [DATA_W+1];
	logic              neg_s [DATA_W+1];
	logic              ovf_s [DATA_W+1];

	logic [DATA_W:0]   t_c  [DATA_W];
	logic              ge_c [DATA_W];
	logic [R0W-1:0]    r0;
	logic              big;

	logic signed [DATA_W-1:0] quo_q;
	logic                     ovf_q;

	// integer part of the quotient must stay below the output range
	assign r0  = un_s1[DOT_W-1:SH];
	assign big = r0 >= R0W'(ud_s1);

	// trial subtract of each stage
	always_comb begin
		for (int i = 0; i < DATA_W; i++) begin
			t_c[i]  = {rem_s[i], low_s[i][DATA_W-1]};
			ge_c[i] = t_c[i] >= {1'b0, ud_s[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// take magnitudes and the result sign
			un_s1  <= num[DOT_W-1] ? DOT_W'(-num) : DOT_W'(num);
			ud_s1  <= den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
			neg_s1 <= num[DOT_W-1] ^ den[DATA_W-1];
			// load the partial remainder with the high dividend bits
			rem_s[0] <= big ? '0 : r0[DATA_W-1:0];
			low_s[0] <= {un_s1[SH-1:0], FRAC_BITS'(0)};
			q_s[0]   <= '0;
			ud_s[0]  <= ud_s1;
			neg_s[0] <= neg_s1;
			ovf_s[0] <= big;
			// one quotient bit per stage
			for (int i = 0; i < DATA_W; i++) begin
				rem_s[i+1] <= ge_c[i] ? DATA_W'(t_c[i] - {1'b0, ud_s[i]}) : t_c[i][DATA_W-1:0];
				low_s[i+1] <= low_s[i] << 1;
				q_s[i+1]   <= {q_s[i][DATA_W-2:0], ge_c[i]};
				ud_s[i+1]  <= ud_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
			// apply sign and clamp
			if (ovf_s[DATA_W]) begin
				quo_q <= neg_s[DATA_W] ? MIN_VAL : MAX_VAL;
				ovf_q <= 1'b1;
			end else if (neg_s[DATA_W]) begin
				if (q_s[DATA_W] > DATA_W'(MIN_VAL)) begin
					quo_q <= MIN_VAL;
					ovf_q <= 1'b1;
				end else begin
					quo_q <= DATA_W'(-q_s[DATA_W]);
					ovf_q <= 1'b0;
				end
			end else if (q_s[DATA_W][DATA_W-1]) begin
				quo_q <= MAX_VAL;
				ovf_q <= 1'b1;
			end else begin
				quo_q <= q_s[DATA_W];
				ovf_q <= 1'b0;
			end
		end
	end

	assign quo = quo_q;
	assign ovf = ovf_q;

endmodule

[sv/hyperdual_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Top level of the hyper-dual arithmetic unit: side line, quotient chain, ALU and output.
//
// Usage: present one operation (opcode, operands a and b, scalar) on the input
// channel with in_valid; it is taken at an edge where in_valid and in_ready are
// both high. Each word yields exactly one result word on the output channel
// (r_real, r_eps1, r_eps2, r_eps12, status), taken when out_valid and out_ready
// are both high. Results leave in input order.
// Throughput: one word per cycle while not stalled. The path from acceptance to
// out_valid runs through three chained 35-stage one-bit-per-stage divider pipelines (value,
// first derivatives, mixed term) with a 3-stage product unit between each, plus
// the final product unit, select stage and output register.
// Every operation travels the full pipeline, so order never changes.
// Stall: while out_valid is high and out_ready low the whole pipeline holds and
// in_ready drops; nothing is lost or repeated. Empty slots are filled as long
// as the output register is free.
// Reset: arst_n clears all valid bits at once; the unit accepts a word in the
// first cycle after reset is released.
module hyperdual_arithmetic_unit import hdau_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               opcode,
	input  logic signed [DATA_W-1:0] a_real,
	input  logic signed [DATA_W-1:0] a_eps1,
	input  logic signed [DATA_W-1:0] a_eps2,
	input  logic signed [DATA_W-1:0] a_eps12,
	input  logic signed [DATA_W-1:0] b_real,
	input  logic signed [DATA_W-1:0] b_eps1,
	input  logic signed [DATA_W-1:0] b_eps2,
	input  logic signed [DATA_W-1:0] b_eps12,
	input  logic signed [DATA_W-1:0] scalar,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] r_real,
	output logic signed [DATA_W-1:0] r_eps1,
	output logic signed [DATA_W-1:0] r_eps2,
	output logic signed [DATA_W-1:0] r_eps12,
	output logic [1:0]               status
);

	logic                en;
	logic [SIDE_N-1:0]   vld_s;
	pipe_t               side_s [SIDE_N];
	pipe_t               side_n [SIDE_N];
	pipe_t               in_word;

	logic signed [DATA_W-1:0] q0, q1, q2, q12;
	logic                     f0, f1, f2, f12;
	logic signed [DOT_W-1:0]  n1, n2, n12;
	logic signed [DOT_W-1:0]  m [4];

	logic signed [DATA_W-1:0] zx [4];
	logic signed [DATA_W-1:0] x1 [4], y1 [4], x2 [4], y2 [4], x3 [4], y3 [4];
	logic signed [DATA_W-1:0] ax [4][4], ay [4][4];

	logic signed [DATA_W-1:0] res [4];
	logic [1:0]               stat;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] r_real_q, r_eps1_q, r_eps2_q, r_eps12_q;
	logic [1:0]               status_q;

	// advance whenever the output register is free or being drained
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	assign in_word = '{op: opcode, a_real: a_real, a_eps1: a_eps1, a_eps2: a_eps2,
		a_eps12: a_eps12, b_real: b_real, b_eps1: b_eps1, b_eps2: b_eps2,
		b_eps12: b_eps12, scalar: scalar, q_real: '0, q_eps1: '0, q_eps2: '0,
		q_eps12: '0, dflag: 1'b0};

	assign zx = '{default: '0};

	// value quotient
	hdau_div u_div_q0 (
		.clk (clk), .en (en),
		.num (DOT_W'(side_s[0].a_real)), .den (side_s[0].b_real),
		.quo (q0), .ovf (f0)
	);

	// numerators of the first-derivative quotients
	assign x1 = '{side_s[T_Q0].q_real, '0, '0, '0};
	assign y1 = '{side_s[T_Q0].b_eps1, '0, '0, '0};
	assign x2 = '{side_s[T_Q0].q_real, '0, '0, '0};
	assign y2 = '{side_s[T_Q0].b_eps2, '0, '0, '0};

	hdau_dot4 u_dot_n1 (
		.clk (clk), .en (en), .x (x1), .y (y1),
		.c (side_s[T_Q0].a_eps1), .sub (1'b1), .res (n1)
	);

	hdau_dot4 u_dot_n2 (
		.clk (clk), .en (en), .x (x2), .y (y2),
		.c (side_s[T_Q0].a_eps2), .sub (1'b1), .res (n2)
	);

	hdau_div u_div_q1 (
		.clk (clk), .en (en),
		.num (n1), .den (side_s[T_Q0+DOT_LAT].b_real),
		.quo (q1), .ovf (f1)
	);

	hdau_div u_div_q2 (
		.clk (clk), .en (en),
		.num (n2), .den (side_s[T_Q0+DOT_LAT].b_real),
		.quo (q2), .ovf (f2)
	);

	// numerator of the mixed quotient
	assign x3 = '{side_s[T_Q12P].q_real, side_s[T_Q12P].q_eps1, side_s[T_Q12P].q_eps2, '0};
	assign y3 = '{side_s[T_Q12P].b_eps12, side_s[T_Q12P].b_eps2, side_s[T_Q12P].b_eps1, '0};

	hdau_dot4 u_dot_n12 (
		.clk (clk), .en (en), .x (x3), .y (y3),
		.c (side_s[T_Q12P].a_eps12), .sub (1'b1), .res (n12)
	);

	hdau_div u_div_q12 (
		.clk (clk), .en (en),
		.num (n12), .den (side_s[T_Q12P+DOT_LAT].b_real),
		.quo (q12), .ovf (f12)
	);

	// product-rule and scale operands
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ax[i] = zx;
			ay[i] = zx;
		end
		unique case (side_s[T_QM].op)
			OP_MUL: begin
				ax[0] = '{side_s[T_QM].a_real, '0, '0, '0};
				ay[0] = '{side_s[T_QM].b_real, '0, '0, '0};
				ax[1] = '{side_s[T_QM].a_eps1, side_s[T_QM].a_real, '0, '0};
				ay[1] = '{side_s[T_QM].b_real, side_s[T_QM].b_eps1, '0, '0};
				ax[2] = '{side_s[T_QM].a_eps2, side_s[T_QM].a_real, '0, '0};
				ay[2] = '{side_s[T_QM].b_real, side_s[T_QM].b_eps2, '0, '0};
				ax[3] = '{side_s[T_QM].a_eps12, side_s[T_QM].a_eps1,
					side_s[T_QM].a_eps2, side_s[T_QM].a_real};
				ay[3] = '{side_s[T_QM].b_real, side_s[T_QM].b_eps2,
					side_s[T_QM].b_eps1, side_s[T_QM].b_eps12};
			end
			OP_SCALE: begin
				ax[0] = '{side_s[T_QM].scalar, '0, '0, '0};
				ay[0] = '{side_s[T_QM].a_real, '0, '0, '0};
				ax[1] = '{side_s[T_QM].scalar, '0, '0, '0};
				ay[1] = '{side_s[T_QM].a_eps1, '0, '0, '0};
				ax[2] = '{side_s[T_QM].scalar, '0, '0, '0};
				ay[2] = '{side_s[T_QM].a_eps2, '0, '0, '0};
				ax[3] = '{side_s[T_QM].scalar, '0, '0, '0};
				ay[3] = '{side_s[T_QM].a_eps12, '0, '0, '0};
			end
			default: begin
			end
		endcase
	end

	for (genvar g = 0; g < 4; g++) begin : g_alu
		hdau_dot4 u_dot_alu (
			.clk (clk), .en (en), .x (ax[g]), .y (ay[g]),
			.c ('0), .sub (1'b0), .res (m[g])
		);
	end

	// shift the side line and merge quotients at their taps
	always_comb begin
		side_n[0] = in_word;
		for (int k = 1; k < SIDE_N; k++) begin
			side_n[k] = side_s[k-1];
		end
		side_n[T_Q0].q_real   = q0;
		side_n[T_Q0].dflag    = side_s[T_Q0-1].dflag | f0;
		side_n[T_Q12P].q_eps1 = q1;
		side_n[T_Q12P].q_eps2 = q2;
		side_n[T_Q12P].dflag  = side_s[T_Q12P-1].dflag | f1 | f2;
		side_n[T_QM].q_eps12  = q12;
		side_n[T_QM].dflag    = side_s[T_QM-1].dflag | f12;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SIDE_N; k++) begin
				side_s[k] <= side_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SIDE_N-2:0], in_valid};
		end
	end

	// select the result of the operation and clamp
	always_comb begin
		logic signed [DATA_W-1:0] av [4];
		logic signed [DATA_W-1:0] bv [4];
		logic signed [DATA_W-1:0] qv [4];
		sat_t                     s;
		logic                     flag;
		logic                     dz;
		av   = '{side_s[T_END].a_real, side_s[T_END].a_eps1,
			side_s[T_END].a_eps2, side_s[T_END].a_eps12};
		bv   = '{side_s[T_END].b_real, side_s[T_END].b_eps1,
			side_s[T_END].b_eps2, side_s[T_END].b_eps12};
		qv   = '{side_s[T_END].q_real, side_s[T_END].q_eps1,
			side_s[T_END].q_eps2, side_s[T_END].q_eps12};
		res  = '{default: '0};
		flag = 1'b0;
		dz   = 1'b0;
		s    = '0;
		unique case (side_s[T_END].op)
			OP_ADD: begin
				for (int i = 0; i < 4; i++) begin
					s      = sat_wide(DOT_W'(av[i]) + DOT_W'(bv[i]));
					res[i] = s.val;
					flag   = flag | s.sat;
				end
			end
			OP_SUB: begin
				for (int i = 0; i < 4; i++) begin
					s      = sat_wide(DOT_W'(av[i]) - DOT_W'(bv[i]));
					res[i] = s.val;
					flag   = flag | s.sat;
				end
			end
			OP_MUL, OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					s      = sat_wide(m[i]);
					res[i] = s.val;
					flag   = flag | s.sat;
				end
			end
			OP_DIV: begin
				if (bv[0] == '0) begin
					dz = 1'b1;
				end else begin
					res  = qv;
					flag = side_s[T_END].dflag;
				end
			end
			OP_NEG: begin
				for (int i = 0; i < 4; i++) begin
					s      = sat_wide(-DOT_W'(av[i]));
					res[i] = s.val;
					flag   = flag | s.sat;
				end
			end
			OP_ABS: begin
				if (av[0] > 0) begin
					res = av;
				end else if (av[0] < 0) begin
					for (int i = 0; i < 4; i++) begin
						s      = sat_wide(-DOT_W'(av[i]));
						res[i] = s.val;
						flag   = flag | s.sat;
					end
				end
			end
			OP_RELU: begin
				if (av[0] > 0) begin
					res = av;
				end
			end
			OP_FROM_SCALAR: begin
				res[0] = side_s[T_END].scalar;
			end
			default: begin
			end
		endcase
		if (dz) begin
			stat = ST_DIV0;
		end else if (flag) begin
			stat = ST_SAT;
		end else begin
			stat = ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[SIDE_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_real_q  <= res[0];
			r_eps1_q  <= res[1];
			r_eps2_q  <= res[2];
			r_eps12_q <= res[3];
			status_q  <= stat;
		end
	end

	assign out_valid = out_valid_q;
	assign r_real    = r_real_q;
	assign r_eps1    = r_eps1_q;
	assign r_eps2    = r_eps2_q;
	assign r_eps12   = r_eps12_q;
	assign status    = status_q;

	// a held pipeline keeps every valid bit
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid bits moved during a stall");

	// an advancing pipeline shifts valid bits by one stage
	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> vld_s[SIDE_N-1:1] == $past(vld_s[SIDE_N-2:0]))
		else $error("valid bits skipped or repeated a stage");

	// an accepted word enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[0])
		else $error("accepted word lost at entry");

	// division by zero gives an all-zero result
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIV0 |->
		r_real == '0 && r_eps1 == '0 && r_eps2 == '0 && r_eps12 == '0)
		else $error("nonzero result with division by zero");

endmodule

[sim/hyperdual_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the hyper-dual arithmetic unit: directed and random words.
module hyperdual_arithmetic_unit_tb;
	import hdau_pkg::*;

	localparam int FB        = 16;
	localparam int CYCLE_CAP = 400000;

	typedef struct {
		logic [3:0]        op;
		logic signed [31:0] a [4];
		logic signed [31:0] b [4];
		logic signed [31:0] c;
	} hd_word_t;

	typedef struct {
		logic signed [31:0] r [4];
		logic [1:0]         st;
	} hd_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] opcode = '0;
	logic signed [31:0] a_real = '0, a_eps1 = '0, a_eps2 = '0, a_eps12 = '0;
	logic signed [31:0] b_real = '0, b_eps1 = '0, b_eps2 = '0, b_eps12 = '0;
	logic signed [31:0] scalar = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] r_real, r_eps1, r_eps2, r_eps12;
	logic [1:0] status;

	hd_result_t expected_q [$];
	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int cycles = 0;

	hyperdual_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .a_real(a_real), .a_eps1(a_eps1), .a_eps2(a_eps2),
		.a_eps12(a_eps12), .b_real(b_real), .b_eps1(b_eps1), .b_eps2(b_eps2),
		.b_eps12(b_eps12), .scalar(scalar), .out_valid(out_valid),
		.out_ready(out_ready), .r_real(r_real), .r_eps1(r_eps1), .r_eps2(r_eps2),
		.r_eps12(r_eps12), .status(status)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// clamp to 32 bits, note saturation
	function automatic logic signed [31:0] clamp32(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// exact sum of products, rounded once (half up); 128 bits keeps four products exact
	function automatic logic signed [127:0] round_dot(input longint x [4], input longint y [4],
			input int n);
		logic signed [127:0] acc;
		acc = 0;
		for (int i = 0; i < n; i++)
			acc += 128'(x[i]) * 128'(y[i]);
		acc += 128'sd1 <<< (FB - 1);
		return acc >>> FB;
	endfunction

	function automatic logic signed [31:0] clamp_wide(input logic signed [127:0] v,
			inout bit sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// fixed-point quotient, truncated toward zero
	function automatic logic signed [31:0] fx_quot(input logic signed [127:0] n, input longint d,
			inout bit sat);
		bit neg;
		logic [127:0] un, ud, qi, rem, mag;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -128'(d) : 128'(d);
		qi = un / ud;
		rem = un % ud;
		if (qi >= (128'd1 << (32 - FB))) begin
			sat = 1'b1;
			return neg ? 32'sh80000000 : 32'sh7fffffff;
		end
		mag = (qi << FB) + ((rem << FB) / ud);
		return clamp_wide(neg ? -$signed(mag) : $signed(mag), sat);
	endfunction

	function automatic hd_result_t hd_compute(input hd_word_t w);
		hd_result_t res;
		longint a [4], b [4], x [4], y [4];
		bit sat;
		sat = 1'b0;
		for (int i = 0; i < 4; i++) begin
			a[i] = w.a[i];
			b[i] = w.b[i];
			res.r[i] = '0;
			x[i] = 0;
			y[i] = 0;
		end
		res.st = ST_OK;
		case (w.op)
			OP_ADD: for (int i = 0; i < 4; i++) res.r[i] = clamp32(a[i] + b[i], sat);
			OP_SUB: for (int i = 0; i < 4; i++) res.r[i] = clamp32(a[i] - b[i], sat);
			OP_MUL: begin
				x[0] = a[0]; y[0] = b[0];
				res.r[0] = clamp_wide(round_dot(x, y, 1), sat);
				x[0] = a[1]; x[1] = a[0]; y[1] = b[1];
				res.r[1] = clamp_wide(round_dot(x, y, 2), sat);
				x[0] = a[2]; y[1] = b[2];
				res.r[2] = clamp_wide(round_dot(x, y, 2), sat);
				x[0] = a[3]; y[0] = b[0]; x[1] = a[1]; y[1] = b[2];
				x[2] = a[2]; y[2] = b[1]; x[3] = a[0]; y[3] = b[3];
				res.r[3] = clamp_wide(round_dot(x, y, 4), sat);
			end
			OP_DIV: begin
				if (b[0] == 0) begin
					res.st = ST_DIV0;
				end else begin
					res.r[0] = fx_quot(128'(a[0]), b[0], sat);
					x[0] = res.r[0]; y[0] = b[1];
					res.r[1] = fx_quot(128'(a[1]) - round_dot(x, y, 1), b[0], sat);
					y[0] = b[2];
					res.r[2] = fx_quot(128'(a[2]) - round_dot(x, y, 1), b[0], sat);
					y[0] = b[3];
					x[1] = res.r[1]; y[1] = b[2];
					x[2] = res.r[2]; y[2] = b[1];
					res.r[3] = fx_quot(128'(a[3]) - round_dot(x, y, 3), b[0], sat);
				end
			end
			OP_NEG: for (int i = 0; i < 4; i++) res.r[i] = clamp32(-a[i], sat);
			OP_ABS: begin
				if (a[0] > 0)
					for (int i = 0; i < 4; i++) res.r[i] = a[i];
				else if (a[0] < 0)
					for (int i = 0; i < 4; i++) res.r[i] = clamp32(-a[i], sat);
			end
			OP_RELU: if (a[0] > 0) for (int i = 0; i < 4; i++) res.r[i] = a[i];
			OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					x[0] = longint'(w.c); y[0] = a[i];
					res.r[i] = clamp_wide(round_dot(x, y, 1), sat);
				end
			end
			OP_FROM_SCALAR: res.r[0] = w.c;
			default: ;
		endcase
		if (res.st == ST_OK && sat)
			res.st = ST_SAT;
		return res;
	endfunction

	// send one word after a random gap; record its expected result
	task automatic send_word(input hd_word_t w, input bit gaps = 1'b1);
		int gap;
		gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14)) : 0;
		// drop valid only across a gap so back-to-back words keep it high
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= w.op;
		a_real <= w.a[0]; a_eps1 <= w.a[1]; a_eps2 <= w.a[2]; a_eps12 <= w.a[3];
		b_real <= w.b[0]; b_eps1 <= w.b[1]; b_eps2 <= w.b[2]; b_eps12 <= w.b[3];
		scalar <= w.c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(hd_compute(w));
		words_sent++;
	endtask

	function automatic logic signed [31:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return $signed($urandom_range(0, 8)) <<< FB;
			4: return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
			5: return -($signed($urandom_range(0, 8)) <<< FB);
			default: return $urandom();
		endcase
	endfunction

	function automatic hd_word_t rand_word(input logic [3:0] op);
		hd_word_t w;
		w.op = op;
		for (int i = 0; i < 4; i++) begin
			w.a[i] = rand_comp();
			w.b[i] = rand_comp();
		end
		w.c = rand_comp();
		return w;
	endfunction

	function automatic hd_word_t fill_word(input logic [3:0] op, input logic signed [31:0] av,
			input logic signed [31:0] bv, input logic signed [31:0] cv);
		hd_word_t w;
		w.op = op;
		for (int i = 0; i < 4; i++) begin
			w.a[i] = av;
			w.b[i] = bv;
		end
		w.c = cv;
		return w;
	endfunction

	// extremes, each operation, and the named special cases
	task automatic test_directed();
		hd_word_t w;
		send_word(fill_word(OP_ADD, 32'sh7fffffff, 32'sh7fffffff, 0));
		send_word(fill_word(OP_ADD, 32'sh80000000, 32'sh80000000, 0));
		send_word(fill_word(OP_SUB, 32'sh80000000, 32'sh7fffffff, 0));
		send_word(fill_word(OP_SUB, 32'sh00030000, 32'sh00010000, 0));
		send_word(fill_word(OP_MUL, 32'sh00018000, 32'sh00028000, 0));
		send_word(fill_word(OP_MUL, 32'sh7fffffff, 32'sh80000000, 0));
		send_word(fill_word(OP_MUL, 32'sh80000000, 32'sh80000000, 0));
		send_word(fill_word(OP_MUL, 32'sh00000001, 32'sh00008000, 0));
		send_word(fill_word(OP_MUL, -32'sh1, 32'sh00008000, 0));
		send_word(fill_word(OP_DIV, 32'sh00030000, 32'sh00020000, 0));
		send_word(fill_word(OP_DIV, 32'sh00010000, 32'sd0, 0));
		send_word(fill_word(OP_DIV, 32'sh7fffffff, 32'sd1, 0));
		send_word(fill_word(OP_DIV, 32'sh80000000, 32'sh80000000, 0));
		send_word(fill_word(OP_DIV, 32'sh80000000, -32'sh00010000, 0));
		send_word(fill_word(OP_NEG, 32'sh80000000, 0, 0));
		send_word(fill_word(OP_NEG, 32'sh00010000, 0, 0));
		send_word(fill_word(OP_ABS, 32'sh80000000, 0, 0));
		send_word(fill_word(OP_ABS, 32'sd0, 0, 0));
		w = fill_word(OP_ABS, -32'sh00020000, 0, 0);
		w.a[1] = 32'sh80000000;
		send_word(w);
		send_word(fill_word(OP_RELU, 32'sh00010000, 0, 0));
		send_word(fill_word(OP_RELU, 32'sd0, 0, 0));
		send_word(fill_word(OP_SCALE, 32'sh7fffffff, 0, 32'sh80000000));
		send_word(fill_word(OP_SCALE, 32'sh00020000, 0, 32'sh00008000));
		send_word(fill_word(OP_FROM_SCALAR, 32'sh11111111, 0, 32'sh80000000));
		send_word(fill_word(4'd15, 32'sh00010000, 32'sh00010000, 32'sh00010000));
	endtask

	// random operations over all codes, mostly valid ones; some bursts without gaps
	task automatic test_random(input int count);
		logic [3:0] op;
		bit burst;
		burst = 1'b0;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 49) == 0)
				burst = !burst;
			op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			send_word(rand_word(op), !burst);
		end
	endtask

	// drive output readiness with random stalls
	initial begin
		int stall;
		forever begin
			@(posedge clk);
			if (!out_ready) begin
				out_ready <= 1'b1;
			end else if (out_valid) begin
				stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall - 1) @(posedge clk);
				end
			end
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		hd_result_t e;
		logic signed [31:0] got [4];
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got[0] = r_real; got[1] = r_eps1; got[2] = r_eps2; got[3] = r_eps12;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result word, actual %h %h %h %h status %0d", $time,
					r_real, r_eps1, r_eps2, r_eps12, status);
				errors++;
			end else begin
				e = expected_q.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i] !== e.r[i]) begin
						$display("%0t: component %0d expected %h actual %h", $time, i,
							e.r[i], got[i]);
						errors++;
					end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
			end
		end
	end

	// guard against a hung pipeline
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("hyperdual_arithmetic_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1450);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		$display("Covered %0d words over all opcodes, saturation and zero divisors;",
			words_sent);
		$display("%0d results checked under random input gaps and output stalls.",
			results_seen);
		if (errors == 0)
			$display("hyperdual_arithmetic_unit_tb: done, clean");
		else
			$display("hyperdual_arithmetic_unit_tb: done, errors");
		$finish;
	end

endmodule
